### rtl/gls_pkg.sv
package gls_pkg;

    // Default sizes
    localparam int MAX_QUBITS_DEF = 64;
    localparam int MAX_LAYERS_DEF = 256;

    // Field widths
    localparam int CMD_W      = 3;
    localparam int Q_W        = 6;
    localparam int CAP_W      = 12;
    localparam int NQ_W       = 7;
    localparam int GW         = 12;
    localparam int ERR_W      = 3;
    localparam int KIND_W     = 2;
    localparam int LAYER_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GATES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_QUBITS = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_BARRIER = 3'd0,
        CMD_PARTIAL = 3'd1,
        CMD_GLOBAL  = 3'd2,
        CMD_SINGLE  = 3'd3,
        CMD_CZ      = 3'd4,
        CMD_UNSUP   = 3'd5,
        CMD_START   = 3'd6
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 3'd0,
        ERR_PARTIAL  = 3'd1,
        ERR_UNSUP    = 3'd2,
        ERR_RANGE    = 3'd3,
        ERR_OVERFLOW = 3'd4
    } err_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_TWO    = 2'd2
    } kind_t;

    // Result selection handed from controller to datapath
    typedef enum logic [2:0] {
        RES_NONE,
        RES_ERR_PARTIAL,
        RES_ERR_UNSUP,
        RES_ERR_RANGE,
        RES_ERR_OVERFLOW,
        RES_SINGLE,
        RES_CZ
    } res_t;

    typedef enum logic [1:0] {
        ADDR_IDX,
        ADDR_QA,
        ADDR_QB
    } nfl_addr_t;

    typedef enum logic [1:0] {
        WD_LAY,
        WD_LAY_INC,
        WD_ZERO
    } nfl_wd_t;

    typedef struct packed {
        logic      capture;
        logic      lay_clr;
        logic      lay_open;
        logic      lay_max;
        logic      lay_inc;
        logic      open_clr;
        logic      open_inc;
        logic      idx_clr;
        logic      idx_inc;
        logic      nfl_rd;
        logic      nfl_wr;
        nfl_addr_t nfl_addr;
        nfl_wd_t   nfl_wd;
        logic      g_wr_inc;
        logic      g_wr_new;
        logic      out_load;
        res_t      res;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic oor_a;
        logic oor_b;
        logic idx_lt_n;
        logic idx_lt_all;
        logic rd_pend;
        logic lay_lt_open;
        logic full;
        logic open_at_max;
        logic out_free;
    } ctrl_stat_t;

endpackage

### rtl/gls_ram.sv
module gls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/gls_dp.sv
module gls_dp #(
    parameter int MAX_QUBITS = gls_pkg::MAX_QUBITS_DEF,
    parameter int MAX_LAYERS = gls_pkg::MAX_LAYERS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gls_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [gls_pkg::CMD_W-1:0]       s_cmd,
    input  logic [gls_pkg::Q_W-1:0]         s_qubit_a,
    input  logic [gls_pkg::Q_W-1:0]         s_qubit_b,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [gls_pkg::ERR_W-1:0]       m_error,
    output logic [gls_pkg::KIND_W-1:0]      m_list_kind,
    output logic [gls_pkg::LAYER_W-1:0]     m_layer,
    output logic [gls_pkg::Q_W-1:0]         m_qubit_low,
    output logic [gls_pkg::Q_W-1:0]         m_qubit_high,
    output logic [gls_pkg::COUNT_W-1:0]     m_layer_count,
    input  gls_pkg::ctrl_cmd_t              ctl,
    output gls_pkg::ctrl_stat_t             stat
);
    import gls_pkg::*;

    localparam int QW = $clog2(MAX_QUBITS);
    localparam int CW = $clog2(MAX_QUBITS + 1);
    localparam int LW = $clog2(MAX_LAYERS);

    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [NQ_W-1:0]    nq_reg, nq_next;
    cmd_t               cmd_reg, cmd_next;
    logic [Q_W-1:0]     qa_reg, qa_next, qb_reg, qb_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [LW-1:0]      lay_reg, lay_next;
    logic [LW-1:0]      open_reg, open_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               m_valid_reg, m_valid_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [LAYER_W-1:0] layer_reg, layer_next;
    logic [Q_W-1:0]     qlo_reg, qlo_next, qhi_reg, qhi_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;

    logic [CW-1:0]  n_eff;
    logic [QW-1:0]  nfl_addr;
    logic [LW-1:0]  nfl_wdata, nfl_rdata;
    logic           g_we;
    logic [LW-1:0]  g_waddr;
    logic [GW-1:0]  g_wdata, g_rdata;
    logic [Q_W-1:0] q_min, q_max;

    // Effective qubit count: the register value, saturated at the array size
    assign n_eff = (32'(nq_reg) > MAX_QUBITS) ? CW'(MAX_QUBITS) : CW'(nq_reg);

    always_comb begin
        case (ctl.nfl_addr)
            ADDR_QA: nfl_addr = QW'(qa_reg);
            ADDR_QB: nfl_addr = QW'(qb_reg);
            default: nfl_addr = idx_reg[QW-1:0];
        endcase
        case (ctl.nfl_wd)
            WD_LAY_INC: nfl_wdata = lay_reg + LW'(1);
            WD_ZERO:    nfl_wdata = '0;
            default:    nfl_wdata = lay_reg;
        endcase
    end

    gls_ram #(.WIDTH(LW), .DEPTH(MAX_QUBITS)) u_nfl_ram (
        .aclk  (aclk),
        .we    (ctl.nfl_wr),
        .waddr (nfl_addr),
        .wdata (nfl_wdata),
        .raddr (nfl_addr),
        .rdata (nfl_rdata)
    );

    // A freshly opened layer starts with this gate, so no clearing is needed
    assign g_we    = ctl.g_wr_inc | ctl.g_wr_new;
    assign g_waddr = ctl.g_wr_new ? open_reg : lay_reg;
    assign g_wdata = ctl.g_wr_new ? GW'(1) : g_rdata + GW'(1);

    gls_ram #(.WIDTH(GW), .DEPTH(MAX_LAYERS)) u_gates_ram (
        .aclk  (aclk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (lay_reg),
        .rdata (g_rdata)
    );

    assign q_min = (qa_reg < qb_reg) ? qa_reg : qb_reg;
    assign q_max = (qa_reg < qb_reg) ? qb_reg : qa_reg;

    always_comb begin
        cap_next     = cap_reg;
        nq_next      = nq_reg;
        cmd_next     = cmd_reg;
        qa_next      = qa_reg;
        qb_next      = qb_reg;
        idx_next     = idx_reg;
        lay_next     = lay_reg;
        open_next    = open_reg;
        rd_pend_next = ctl.nfl_rd;
        m_valid_next = m_valid_reg;
        err_next     = err_reg;
        kind_next    = kind_reg;
        layer_next   = layer_reg;
        qlo_next     = qlo_reg;
        qhi_next     = qhi_reg;
        cnt_next     = cnt_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_GATES:  cap_next = cfg_data[CAP_W-1:0];
                CFG_NUM_QUBITS: nq_next  = cfg_data[NQ_W-1:0];
                default: ;
            endcase
        end

        if (ctl.capture) begin
            cmd_next = cmd_t'(s_cmd);
            qa_next  = s_qubit_a;
            qb_next  = s_qubit_b;
        end

        if (ctl.idx_clr) begin
            idx_next = '0;
        end else if (ctl.idx_inc) begin
            idx_next = idx_reg + CW'(1);
        end

        if (ctl.lay_clr) begin
            lay_next = '0;
        end else if (ctl.lay_open) begin
            lay_next = open_reg;
        end else if (ctl.lay_inc) begin
            lay_next = lay_reg + LW'(1);
        end else if (ctl.lay_max && rd_pend_reg && nfl_rdata > lay_reg) begin
            lay_next = nfl_rdata;
        end

        if (ctl.open_clr) begin
            open_next = '0;
        end else if (ctl.open_inc) begin
            open_next = open_reg + LW'(1);
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctl.out_load) begin
            m_valid_next = 1'b1;
            err_next     = ERR_OK;
            kind_next    = KIND_NONE;
            layer_next   = '0;
            qlo_next     = '0;
            qhi_next     = '0;
            cnt_next     = COUNT_W'(open_reg);
            case (ctl.res)
                RES_ERR_PARTIAL:  err_next = ERR_PARTIAL;
                RES_ERR_UNSUP:    err_next = ERR_UNSUP;
                RES_ERR_RANGE:    err_next = ERR_RANGE;
                RES_ERR_OVERFLOW: err_next = ERR_OVERFLOW;
                RES_SINGLE: begin
                    kind_next  = KIND_SINGLE;
                    layer_next = LAYER_W'(lay_reg);
                end
                RES_CZ: begin
                    kind_next  = KIND_TWO;
                    layer_next = LAYER_W'(lay_reg);
                    qlo_next   = q_min;
                    qhi_next   = q_max;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_W'(1);
            nq_reg      <= NQ_W'(64);
            idx_reg     <= '0;
            open_reg    <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cap_reg     <= cap_next;
            nq_reg      <= nq_next;
            idx_reg     <= idx_next;
            open_reg    <= open_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg   <= cmd_next;
        qa_reg    <= qa_next;
        qb_reg    <= qb_next;
        lay_reg   <= lay_next;
        err_reg   <= err_next;
        kind_reg  <= kind_next;
        layer_reg <= layer_next;
        qlo_reg   <= qlo_next;
        qhi_reg   <= qhi_next;
        cnt_reg   <= cnt_next;
    end

    assign stat.cmd         = cmd_reg;
    assign stat.oor_a       = 32'(qa_reg) >= 32'(n_eff);
    assign stat.oor_b       = 32'(qb_reg) >= 32'(n_eff);
    assign stat.idx_lt_n    = idx_reg < n_eff;
    assign stat.idx_lt_all  = 32'(idx_reg) < MAX_QUBITS;
    assign stat.rd_pend     = rd_pend_reg;
    assign stat.lay_lt_open = lay_reg < open_reg;
    assign stat.full        = g_rdata >= cap_reg;
    assign stat.open_at_max = 32'(open_reg) >= MAX_LAYERS - 1;
    assign stat.out_free    = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_error       = err_reg;
    assign m_list_kind   = kind_reg;
    assign m_layer       = layer_reg;
    assign m_qubit_low   = qlo_reg;
    assign m_qubit_high  = qhi_reg;
    assign m_layer_count = cnt_reg;

endmodule

### rtl/gls_ctrl.sv
module gls_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gls_pkg::ctrl_stat_t  stat,
    output gls_pkg::ctrl_cmd_t   ctl
);
    import gls_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_SG_WAIT,
        ST_CZ_B,
        ST_CZ_C,
        ST_SKIP,
        ST_SKIP_CHK,
        ST_OPEN,
        ST_UPD_A,
        ST_UPD_B,
        ST_SCAN,
        ST_SWEEP,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    always_comb begin
        state_next = state_reg;
        res_next   = res_reg;
        ctl        = '0;
        ctl.res    = res_reg;

        case (state_reg)
            ST_INIT: begin
                if (stat.idx_lt_all) begin
                    ctl.nfl_wr  = 1'b1;
                    ctl.nfl_wd  = WD_ZERO;
                    ctl.idx_inc = 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.cmd)
                    CMD_BARRIER: begin
                        ctl.lay_open = 1'b1;
                        ctl.idx_clr  = 1'b1;
                        res_next     = RES_NONE;
                        state_next   = ST_SWEEP;
                    end
                    CMD_PARTIAL: begin
                        res_next   = RES_ERR_PARTIAL;
                        state_next = ST_FINISH;
                    end
                    CMD_GLOBAL: begin
                        ctl.lay_clr = 1'b1;
                        ctl.idx_clr = 1'b1;
                        res_next    = RES_SINGLE;
                        state_next  = ST_SCAN;
                    end
                    CMD_SINGLE: begin
                        if (stat.oor_a) begin
                            res_next   = RES_ERR_RANGE;
                            state_next = ST_FINISH;
                        end else begin
                            ctl.nfl_rd   = 1'b1;
                            ctl.nfl_addr = ADDR_QA;
                            ctl.lay_clr  = 1'b1;
                            res_next     = RES_SINGLE;
                            state_next   = ST_SG_WAIT;
                        end
                    end
                    CMD_CZ: begin
                        if (stat.oor_a || stat.oor_b) begin
                            res_next   = RES_ERR_RANGE;
                            state_next = ST_FINISH;
                        end else begin
                            ctl.nfl_rd   = 1'b1;
                            ctl.nfl_addr = ADDR_QA;
                            ctl.lay_clr  = 1'b1;
                            res_next     = RES_CZ;
                            state_next   = ST_CZ_B;
                        end
                    end
                    CMD_START: begin
                        ctl.open_clr = 1'b1;
                        ctl.idx_clr  = 1'b1;
                        res_next     = RES_NONE;
                        state_next   = ST_CLEAR;
                    end
                    default: begin
                        res_next   = RES_ERR_UNSUP;
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SG_WAIT: begin
                ctl.lay_max = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_CZ_B: begin
                ctl.lay_max  = 1'b1;
                ctl.nfl_rd   = 1'b1;
                ctl.nfl_addr = ADDR_QB;
                state_next   = ST_CZ_C;
            end
            ST_CZ_C: begin
                ctl.lay_max = 1'b1;
                state_next  = ST_SKIP;
            end
            ST_SKIP: begin
                // layer count RAM is read at the candidate layer every cycle
                state_next = stat.lay_lt_open ? ST_SKIP_CHK : ST_OPEN;
            end
            ST_SKIP_CHK: begin
                if (stat.full) begin
                    ctl.lay_inc = 1'b1;
                    state_next  = ST_SKIP;
                end else begin
                    ctl.g_wr_inc = 1'b1;
                    state_next   = ST_UPD_A;
                end
            end
            ST_OPEN: begin
                if (stat.open_at_max) begin
                    res_next   = RES_ERR_OVERFLOW;
                    state_next = ST_FINISH;
                end else begin
                    ctl.g_wr_new = 1'b1;
                    ctl.lay_open = 1'b1;
                    ctl.open_inc = 1'b1;
                    state_next   = ST_UPD_A;
                end
            end
            ST_UPD_A: begin
                ctl.nfl_wr   = 1'b1;
                ctl.nfl_addr = ADDR_QA;
                ctl.nfl_wd   = WD_LAY_INC;
                state_next   = ST_UPD_B;
            end
            ST_UPD_B: begin
                ctl.nfl_wr   = 1'b1;
                ctl.nfl_addr = ADDR_QB;
                ctl.nfl_wd   = WD_LAY_INC;
                state_next   = ST_FINISH;
            end
            ST_SCAN: begin
                // reads are pipelined; the running max is updated from each read in the following cycle
                ctl.lay_max = 1'b1;
                if (stat.idx_lt_n) begin
                    ctl.nfl_rd  = 1'b1;
                    ctl.idx_inc = 1'b1;
                end else if (!stat.rd_pend) begin
                    ctl.idx_clr = 1'b1;
                    state_next  = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (stat.idx_lt_n) begin
                    ctl.nfl_wr  = 1'b1;
                    ctl.nfl_wd  = WD_LAY;
                    ctl.idx_inc = 1'b1;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_CLEAR: begin
                if (stat.idx_lt_all) begin
                    ctl.nfl_wr  = 1'b1;
                    ctl.nfl_wd  = WD_ZERO;
                    ctl.idx_inc = 1'b1;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            res_reg   <= RES_NONE;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

### rtl/gate_layer_scheduler_top.sv
// One operation in flight; the next transfer is taken the cycle after the result is loaded
// into the output register. Reset is synchronous, active low; a clearing pass over the
// per-qubit layer RAM follows, s_ready low.
module gate_layer_scheduler_top #(
    parameter int MAX_QUBITS = gls_pkg::MAX_QUBITS_DEF,
    parameter int MAX_LAYERS = gls_pkg::MAX_LAYERS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gls_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gls_pkg::CMD_W-1:0]       s_cmd,
    input  logic [gls_pkg::Q_W-1:0]         s_qubit_a,
    input  logic [gls_pkg::Q_W-1:0]         s_qubit_b,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gls_pkg::ERR_W-1:0]       m_error,
    output logic [gls_pkg::KIND_W-1:0]      m_list_kind,
    output logic [gls_pkg::LAYER_W-1:0]     m_layer,
    output logic [gls_pkg::Q_W-1:0]         m_qubit_low,
    output logic [gls_pkg::Q_W-1:0]         m_qubit_high,
    output logic [gls_pkg::COUNT_W-1:0]     m_layer_count
);
    import gls_pkg::*;

    ctrl_cmd_t  ctl;
    ctrl_stat_t stat;

    gls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    gls_dp #(.MAX_QUBITS(MAX_QUBITS), .MAX_LAYERS(MAX_LAYERS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_cmd         (s_cmd),
        .s_qubit_a     (s_qubit_a),
        .s_qubit_b     (s_qubit_b),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_error       (m_error),
        .m_list_kind   (m_list_kind),
        .m_layer       (m_layer),
        .m_qubit_low   (m_qubit_low),
        .m_qubit_high  (m_qubit_high),
        .m_layer_count (m_layer_count),
        .ctl           (ctl),
        .stat          (stat)
    );

endmodule

### rtl/gls_checker.sv
module gls_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [gls_pkg::ERR_W-1:0]       m_error,
    input logic [gls_pkg::KIND_W-1:0]      m_list_kind,
    input logic [gls_pkg::LAYER_W-1:0]     m_layer,
    input logic [gls_pkg::Q_W-1:0]         m_qubit_low,
    input logic [gls_pkg::Q_W-1:0]         m_qubit_high,
    input logic [gls_pkg::COUNT_W-1:0]     m_layer_count
);
    import gls_pkg::*;

    // held result (error, kind, layer, count) must not change until transferred
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_error) && $stable(m_layer)
            && $stable(m_list_kind) && $stable(m_layer_count))
        else $error("result changed while stalled");

    // one operation at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error != ERR_OK |-> m_list_kind == KIND_NONE && m_layer == '0
            && m_qubit_low == '0 && m_qubit_high == '0)
        else $error("error result carries placement");

    a_cz_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_list_kind == KIND_TWO |-> m_qubit_low <= m_qubit_high
            && COUNT_W'(m_layer) < m_layer_count)
        else $error("cz placement inconsistent");

    a_non_cz_qubits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_list_kind != KIND_TWO |-> m_qubit_low == '0 && m_qubit_high == '0)
        else $error("qubit pair on non-cz result");

endmodule

bind gate_layer_scheduler_top gls_checker u_gls_checker (.*);

### tb/sv/tb_gate_layer_scheduler_top.sv
module tb_gate_layer_scheduler_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gls_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam logic [CMD_W-1:0] CMD_UNDEF = 3'd7;

    typedef struct packed {
        logic [ERR_W-1:0]   error;
        logic [KIND_W-1:0]  list_kind;
        logic [LAYER_W-1:0] layer;
        logic [Q_W-1:0]     qubit_low;
        logic [Q_W-1:0]     qubit_high;
        logic [COUNT_W-1:0] layer_count;
    } sched_result_t;

    // Layer placement model plus the queue of placements still owed by the block
    class layer_scoreboard;
        bit [8:0]        next_layer[MAX_QUBITS_DEF];
        bit [GW-1:0]     layer_fill[MAX_LAYERS_DEF];
        bit [8:0]        opened;
        bit [CAP_W-1:0]  capacity = 1;
        bit [NQ_W-1:0]   qubits = 64;
        sched_result_t   placements[$];
        int              mismatches;
        int              checked;
        int              cz_placed;
        int              range_errs;
        int              overflows;

        function void clear_layers();
            foreach (next_layer[i]) next_layer[i] = '0;
            foreach (layer_fill[i]) layer_fill[i] = '0;
            opened = '0;
        endfunction

        function int nq_eff();
            return (int'(qubits) > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : int'(qubits);
        endfunction

        function int pending();
            return placements.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_MAX_GATES)
                capacity = data[CAP_W-1:0];
            else
                qubits = data[NQ_W-1:0];
        endfunction

        function void note_op(logic [CMD_W-1:0] cmd, logic [Q_W-1:0] qa, logic [Q_W-1:0] qb);
            sched_result_t r;
            int n;
            int q;
            int lay;
            r = '0;
            n = nq_eff();
            case (cmd)
                CMD_BARRIER: begin
                    for (q = 0; q < n; q++) next_layer[q] = opened;
                end
                CMD_PARTIAL: r.error = ERR_PARTIAL;
                CMD_GLOBAL: begin
                    lay = 0;
                    for (q = 0; q < n; q++)
                        if (int'(next_layer[q]) > lay) lay = int'(next_layer[q]);
                    for (q = 0; q < n; q++) next_layer[q] = 9'(lay);
                    r.list_kind = KIND_SINGLE;
                    r.layer = lay[7:0];
                end
                CMD_SINGLE: begin
                    if (int'(qa) >= n) begin
                        r.error = ERR_RANGE;
                    end else begin
                        r.list_kind = KIND_SINGLE;
                        r.layer = next_layer[qa][7:0];
                    end
                end
                CMD_CZ: begin
                    if (int'(qa) >= n || int'(qb) >= n) begin
                        r.error = ERR_RANGE;
                    end else begin
                        lay = int'(next_layer[qa]);
                        if (int'(next_layer[qb]) > lay) lay = int'(next_layer[qb]);
                        while (lay < int'(opened) && layer_fill[lay] >= capacity) lay++;
                        if (lay >= int'(opened)) begin
                            // a fresh two-qubit layer also costs a single-qubit one
                            if (int'(opened) >= MAX_LAYERS_DEF - 1) begin
                                r.error = ERR_OVERFLOW;
                            end else begin
                                lay = int'(opened);
                                layer_fill[lay] = '0;
                                opened++;
                            end
                        end
                        if (r.error == ERR_OK) begin
                            layer_fill[lay] = layer_fill[lay] + GW'(1);
                            next_layer[qa] = 9'(lay + 1);
                            next_layer[qb] = 9'(lay + 1);
                            r.list_kind = KIND_TWO;
                            r.layer = lay[7:0];
                            r.qubit_low = (qa < qb) ? qa : qb;
                            r.qubit_high = (qa < qb) ? qb : qa;
                        end
                    end
                end
                CMD_START: clear_layers();
                default: r.error = ERR_UNSUP;
            endcase
            r.layer_count = opened;
            if (r.list_kind == KIND_TWO) cz_placed++;
            if (r.error == ERR_RANGE) range_errs++;
            if (r.error == ERR_OVERFLOW) overflows++;
            placements.push_back(r);
        endfunction

        function void report(string what, sched_result_t want, sched_result_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] %s", $time, what);
                $display("    exp err=%0d kind=%0d layer=%0d pair=(%0d,%0d) cnt=%0d",
                         want.error, want.list_kind, want.layer, want.qubit_low,
                         want.qubit_high, want.layer_count);
                $display("    got err=%0d kind=%0d layer=%0d pair=(%0d,%0d) cnt=%0d",
                         got.error, got.list_kind, got.layer, got.qubit_low,
                         got.qubit_high, got.layer_count);
            end
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            string diff;
            if (placements.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            want = placements.pop_front();
            checked++;
            diff = "";
            if (got.error !== want.error) diff = {diff, " error"};
            if (got.list_kind !== want.list_kind) diff = {diff, " list_kind"};
            if (got.layer !== want.layer) diff = {diff, " layer"};
            if (got.qubit_low !== want.qubit_low) diff = {diff, " qubit_low"};
            if (got.qubit_high !== want.qubit_high) diff = {diff, " qubit_high"};
            if (got.layer_count !== want.layer_count) diff = {diff, " layer_count"};
            if (diff != "") report($sformatf("result %0d differs in%s", checked, diff), want, got);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd = '0;
    logic [Q_W-1:0]        s_qubit_a = '0;
    logic [Q_W-1:0]        s_qubit_b = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ERR_W-1:0]      m_error;
    logic [KIND_W-1:0]     m_list_kind;
    logic [LAYER_W-1:0]    m_layer;
    logic [Q_W-1:0]        m_qubit_low;
    logic [Q_W-1:0]        m_qubit_high;
    logic [COUNT_W-1:0]    m_layer_count;

    layer_scoreboard sb = new();
    bit send_idle;
    bit recv_idle;
    bit hold_req;
    int ops_sent;
    int quiet_cycles;

    gate_layer_scheduler_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_qubit_a     (s_qubit_a),
        .s_qubit_b     (s_qubit_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_error       (m_error),
        .m_list_kind   (m_list_kind),
        .m_layer       (m_layer),
        .m_qubit_low   (m_qubit_low),
        .m_qubit_high  (m_qubit_high),
        .m_layer_count (m_layer_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Nothing transferred on either side for too long means the block has hung
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, sb.pending());
            $display("tb_gate_layer_scheduler_top: FAIL");
            $finish;
        end
    end

    initial begin : result_sink
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                gap = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                gap = recv_idle ? $urandom_range(0, 7) : 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.check_result({m_error, m_list_kind, m_layer, m_qubit_low, m_qubit_high,
                             m_layer_count});
        end
    end

    task automatic send_op(input logic [CMD_W-1:0] c, input logic [Q_W-1:0] a,
                           input logic [Q_W-1:0] b);
        int gap;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= c;
        s_qubit_a <= a;
        s_qubit_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_op(c, a, b);
        ops_sent++;
    endtask

    // Stop offering and wait for every owed result, so the block is idle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] cap,
                              input logic [CFG_DATA_W-1:0] nq);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_GATES;
        cfg_data  <= cap;
        @(posedge aclk);
        cfg_index <= CFG_NUM_QUBITS;
        cfg_data  <= nq;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.write_reg(CFG_MAX_GATES, cap);
        sb.write_reg(CFG_NUM_QUBITS, nq);
    endtask

    // Mostly in-range gates, a thin tail of global gates, barriers, restarts and raw noise
    task automatic run_random(input int count, input int cz_pct, input bit restarts,
                              input int hold_at);
        logic [CMD_W-1:0] c;
        logic [Q_W-1:0]   a;
        logic [Q_W-1:0]   b;
        int roll;
        int top;
        send_op(CMD_START, Q_W'($urandom_range(0, 63)), Q_W'($urandom_range(0, 63)));
        for (int i = 1; i < count; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            top  = (sb.nq_eff() > 0) ? sb.nq_eff() - 1 : 0;
            roll = $urandom_range(0, 99);
            a    = Q_W'($urandom_range(0, top));
            b    = Q_W'($urandom_range(0, top));
            if (roll < cz_pct)
                c = CMD_CZ;
            else if (roll < 90)
                c = CMD_SINGLE;
            else if (roll < 94)
                c = CMD_GLOBAL;
            else if (roll < 97)
                c = CMD_BARRIER;
            else if (roll == 97 && restarts)
                c = CMD_START;
            else begin
                c = CMD_W'($urandom_range(0, 7));
                a = Q_W'($urandom_range(0, 63));
                b = Q_W'($urandom_range(0, 63));
            end
            send_op(c, a, b);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings first, capacity one and all 64 qubits
        send_op(CMD_SINGLE, 0, 0);
        send_op(CMD_SINGLE, 63, 63);
        send_op(CMD_CZ, 0, 63);
        send_op(CMD_CZ, 63, 0);
        send_op(CMD_CZ, 5, 5);
        send_op(CMD_GLOBAL, 0, 0);
        send_op(CMD_SINGLE, 5, 42);
        send_op(CMD_BARRIER, 63, 63);
        send_op(CMD_PARTIAL, 21, 42);
        send_op(CMD_UNSUP, 63, 0);
        send_op(CMD_UNDEF, 0, 63);
        send_op(CMD_START, 63, 63);
        send_op(CMD_CZ, 1, 2);
        drain();

        // capacity zero: each cz opens a layer; three qubits so 3 and up are out of range
        set_config(0, 3);
        send_op(CMD_CZ, 0, 1);
        send_op(CMD_CZ, 0, 1);
        send_op(CMD_CZ, 2, 0);
        send_op(CMD_SINGLE, 3, 0);
        send_op(CMD_CZ, 1, 3);
        send_op(CMD_CZ, 63, 0);
        send_op(CMD_GLOBAL, 0, 0);
        drain();

        // no qubits at all
        set_config(4095, 0);
        send_op(CMD_GLOBAL, 0, 0);
        send_op(CMD_BARRIER, 0, 0);
        send_op(CMD_SINGLE, 0, 0);
        send_op(CMD_CZ, 0, 0);
        drain();

        // small register file, capacity two: plenty of skipping over full layers
        set_config(2, 8);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        run_random(50, 60, 1'b1, -1);
        drain();
        run_random(50, 60, 1'b1, -1);
        drain();

        // cz-heavy with capacity one runs into layer overflow; receiver backs off once
        set_config(1, 64);
        send_idle = 1'b0;
        recv_idle = 1'b1;
        run_random(330, 85, 1'b0, 40);
        drain();

        set_config(0, 5);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        run_random(80, 50, 1'b1, -1);
        drain();

        // upper data bits set: qubit count reads as 127, used as 64
        set_config(4095, 12'hFFF);
        send_idle = 1'b1;
        recv_idle = 1'b0;
        run_random(80, 60, 1'b1, -1);
        drain();

        set_config(3, 64);
        send_idle = 1'b0;
        recv_idle = 1'b1;
        run_random(80, 60, 1'b1, -1);
        drain();
        repeat (10) @(posedge aclk);

        $display("%0d operations sent, %0d results checked, %0d mismatches",
                  ops_sent, sb.checked, sb.mismatches);
        $display("cz placed %0d, range errors %0d, overflows %0d; capacity 0..4095, qubits 0..127",
                  sb.cz_placed, sb.range_errs, sb.overflows);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_gate_layer_scheduler_top: PASS");
        end else begin
            $display("%0d results never arrived", sb.pending());
            $display("tb_gate_layer_scheduler_top: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/gls_pkg.sv
rtl/gls_ram.sv
rtl/gls_dp.sv
rtl/gls_ctrl.sv
rtl/gate_layer_scheduler_top.sv
rtl/gls_checker.sv
tb/sv/tb_gate_layer_scheduler_top.sv
